// ===== design/kmsa_pkg.sv =====
// Package: sizes, codes and shared types of the kernel max-splat accumulator.
package kmsa_pkg;

  localparam int LENGTH_MAX = 4096;
  localparam int HALF_MAX   = 64;
  localparam int ACC_BITS   = 32;

  localparam int TAP_COUNT  = 2 * HALF_MAX + 1;
  localparam int ADDR_W     = $clog2(LENGTH_MAX);
  localparam int TAP_AW     = $clog2(TAP_COUNT);
  localparam int CNT_W      = ADDR_W + 1;

  localparam int OP_W       = 3;
  localparam int POS_W      = 16;
  localparam int IDX_W      = 12;
  localparam int VAL_W      = 32;
  localparam int TAP_W      = 16;
  localparam int LEN_W      = 13;
  localparam int HALF_W     = 7;
  localparam int OFF_W      = 14;
  localparam int BIN_W      = 18;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [ACC_BITS-1:0] FULL_SCALE = '1;
  localparam logic [TAP_W-1:0]    TAP_MAX    = '1;

  typedef enum logic [OP_W-1:0] {
    OP_EVENT    = 3'd0,
    OP_LOAD_TAP = 3'd1,
    OP_COMMIT   = 3'd2,
    OP_READ     = 3'd3,
    OP_WRITE    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_ACTIVE_LENGTH = 2'd0,
    REG_HALF_WIDTH    = 2'd1,
    REG_PEAK_OFFSET   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVENT,
    ST_COMMIT,
    ST_DRAIN,
    ST_READ,
    ST_RDATA,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]         active_length;
    logic [HALF_W-1:0]        half_width;
    logic signed [OFF_W-1:0]  peak_offset;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   pa_raddr;
    logic                pa_we;
    logic [ADDR_W-1:0]   pa_waddr;
    logic [TAP_W-1:0]    pa_wdata;
    logic [ADDR_W-1:0]   ov_raddr;
    logic                ov_we;
    logic [ADDR_W-1:0]   ov_waddr;
    logic [ACC_BITS-1:0] ov_wdata;
    logic [TAP_AW-1:0]   tp_raddr;
    logic                tp_we;
    logic [TAP_AW-1:0]   tp_waddr;
    logic [TAP_W-1:0]    tp_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [TAP_W-1:0]    pa_rdata;
    logic [ACC_BITS-1:0] ov_rdata;
    logic [TAP_W-1:0]    tp_rdata;
  } mem_rsp_t;

endpackage

// ===== design/kmsa_cmd_if.sv =====
// Interface: command channel (valid, ready and one input item).
interface kmsa_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [kmsa_pkg::OP_W-1:0]            op;
  logic signed [kmsa_pkg::POS_W-1:0]    position;
  logic [kmsa_pkg::IDX_W-1:0]           index;
  logic [kmsa_pkg::VAL_W-1:0]           value;

  modport source (output valid, op, position, index, value, input ready);
  modport sink   (input valid, op, position, index, value, output ready);
endinterface

// ===== design/kmsa_res_if.sv =====
// Interface: result channel (valid, ready and one result item).
interface kmsa_res_if;
  logic                          valid;
  logic                          ready;
  logic [kmsa_pkg::OP_W-1:0]     done_op;
  logic [kmsa_pkg::VAL_W-1:0]    read_value;
  logic                          saturated;

  modport source (output valid, done_op, read_value, saturated, input ready);
  modport sink   (input valid, done_op, read_value, saturated, output ready);
endinterface

// ===== design/kmsa_cfg.sv =====
// APB register file: active length, half width and peak offset.
module kmsa_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kmsa_pkg::PADDR_W-1:0]    paddr,
  input  logic [kmsa_pkg::PDATA_W-1:0]    pwdata,
  output logic [kmsa_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output kmsa_pkg::cfg_t                  cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_length <= kmsa_pkg::LEN_W'(kmsa_pkg::LENGTH_MAX);
      cfg.half_width    <= '0;
      cfg.peak_offset   <= '0;
    end else if (wr) begin
      unique case (paddr[3:2])
        kmsa_pkg::REG_ACTIVE_LENGTH: cfg.active_length <= pwdata[kmsa_pkg::LEN_W-1:0];
        kmsa_pkg::REG_HALF_WIDTH:    cfg.half_width    <= pwdata[kmsa_pkg::HALF_W-1:0];
        kmsa_pkg::REG_PEAK_OFFSET:   cfg.peak_offset   <= pwdata[kmsa_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      kmsa_pkg::REG_ACTIVE_LENGTH: prdata = kmsa_pkg::PDATA_W'(cfg.active_length);
      kmsa_pkg::REG_HALF_WIDTH:    prdata = kmsa_pkg::PDATA_W'(cfg.half_width);
      kmsa_pkg::REG_PEAK_OFFSET:   prdata = kmsa_pkg::PDATA_W'(cfg.peak_offset);
      default:                     prdata = '0;
    endcase
  end

endmodule

// ===== design/kmsa_stores.sv =====
// Storage: participant, overall and kernel tap memories, registered read data.
module kmsa_stores (
  input  logic                clk,
  input  kmsa_pkg::mem_req_t  req,
  output kmsa_pkg::mem_rsp_t  rsp
);

  logic [kmsa_pkg::TAP_W-1:0]    pa_mem [kmsa_pkg::LENGTH_MAX];
  logic [kmsa_pkg::ACC_BITS-1:0] ov_mem [kmsa_pkg::LENGTH_MAX];
  logic [kmsa_pkg::TAP_W-1:0]    tp_mem [kmsa_pkg::TAP_COUNT];

  always_ff @(posedge clk) begin
    if (req.pa_we) begin
      pa_mem[req.pa_waddr] <= req.pa_wdata;
    end
    rsp.pa_rdata <= pa_mem[req.pa_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.ov_we) begin
      ov_mem[req.ov_waddr] <= req.ov_wdata;
    end
    rsp.ov_rdata <= ov_mem[req.ov_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.tp_we) begin
      tp_mem[req.tp_waddr] <= req.tp_wdata;
    end
    rsp.tp_rdata <= tp_mem[req.tp_raddr];
  end

endmodule

// ===== design/kmsa_ctrl.sv =====
// Sequencer: op decode, read-modify-write walks over the stores, result register.
module kmsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  kmsa_pkg::cfg_t      cfg,
  kmsa_cmd_if.sink            cmd,
  kmsa_res_if.source          res,
  output kmsa_pkg::mem_req_t  req,
  input  kmsa_pkg::mem_rsp_t  rsp
);

  localparam logic [kmsa_pkg::CNT_W-1:0] LAST_BIN = kmsa_pkg::CNT_W'(kmsa_pkg::LENGTH_MAX - 1);

  kmsa_pkg::state_t state, state_next;
  logic [kmsa_pkg::CNT_W-1:0]        cnt, cnt_next;
  logic signed [kmsa_pkg::BIN_W-1:0] base;
  logic [kmsa_pkg::TAP_AW-1:0]       tap_last;
  logic [kmsa_pkg::OP_W-1:0]         op_r;
  logic [kmsa_pkg::IDX_W-1:0]        idx_r;
  logic [kmsa_pkg::ACC_BITS-1:0]     rd_r;
  logic                              sat_r;
  logic                              s1_ev, s1_cm, s1_ok;
  logic [kmsa_pkg::ADDR_W-1:0]       s1_addr;
  logic                              out_valid;
  logic [kmsa_pkg::OP_W-1:0]         out_op;
  logic [kmsa_pkg::VAL_W-1:0]        out_value;
  logic                              out_sat;

  logic                              accept, ev_issue, cm_issue, finish;
  logic [kmsa_pkg::LEN_W-1:0]        len;
  logic [kmsa_pkg::HALF_W-1:0]       half;
  logic [kmsa_pkg::BIN_W-1:0]        bin;
  logic                              bin_ok;
  logic [kmsa_pkg::ACC_BITS:0]       sum;
  logic [kmsa_pkg::ACC_BITS-1:0]     wr_acc;
  logic [kmsa_pkg::TAP_W-1:0]        wr_tap;

  // Clamp the registers to the sizes that the stores have.
  assign len  = (cfg.active_length > kmsa_pkg::LEN_W'(kmsa_pkg::LENGTH_MAX))
              ? kmsa_pkg::LEN_W'(kmsa_pkg::LENGTH_MAX) : cfg.active_length;
  assign half = (cfg.half_width > kmsa_pkg::HALF_W'(kmsa_pkg::HALF_MAX))
              ? kmsa_pkg::HALF_W'(kmsa_pkg::HALF_MAX) : cfg.half_width;

  assign bin    = base + kmsa_pkg::BIN_W'(cnt);
  assign bin_ok = !bin[kmsa_pkg::BIN_W-1] && (bin < kmsa_pkg::BIN_W'(len));
  assign sum    = {1'b0, rsp.ov_rdata} + (kmsa_pkg::ACC_BITS + 1)'(rsp.pa_rdata);
  assign wr_acc = (64'(cmd.value) > 64'(kmsa_pkg::FULL_SCALE))
                ? kmsa_pkg::FULL_SCALE : kmsa_pkg::ACC_BITS'(cmd.value);
  assign wr_tap = (cmd.value > kmsa_pkg::VAL_W'(kmsa_pkg::TAP_MAX))
                ? kmsa_pkg::TAP_MAX : cmd.value[kmsa_pkg::TAP_W-1:0];

  assign cmd.ready      = (state == kmsa_pkg::ST_IDLE);
  assign accept         = cmd.valid && cmd.ready;
  assign res.valid      = out_valid;
  assign res.done_op    = out_op;
  assign res.read_value = out_value;
  assign res.saturated  = out_sat;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    req        = '0;
    ev_issue   = 1'b0;
    cm_issue   = 1'b0;
    finish     = 1'b0;
    unique case (state)
      kmsa_pkg::ST_CLEAR: begin
        req.pa_we    = 1'b1;
        req.pa_waddr = cnt[kmsa_pkg::ADDR_W-1:0];
        req.ov_we    = 1'b1;
        req.ov_waddr = cnt[kmsa_pkg::ADDR_W-1:0];
        req.tp_we    = (cnt < kmsa_pkg::CNT_W'(kmsa_pkg::TAP_COUNT));
        req.tp_waddr = cnt[kmsa_pkg::TAP_AW-1:0];
        if (cnt == LAST_BIN) begin
          state_next = kmsa_pkg::ST_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      kmsa_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          unique case (cmd.op)
            kmsa_pkg::OP_EVENT:  state_next = kmsa_pkg::ST_EVENT;
            kmsa_pkg::OP_COMMIT: state_next = kmsa_pkg::ST_COMMIT;
            kmsa_pkg::OP_READ:   state_next = kmsa_pkg::ST_READ;
            kmsa_pkg::OP_LOAD_TAP: begin
              req.tp_we    = (32'(cmd.index) < 32'(kmsa_pkg::TAP_COUNT));
              req.tp_waddr = kmsa_pkg::TAP_AW'(cmd.index);
              req.tp_wdata = wr_tap;
              state_next   = kmsa_pkg::ST_FINISH;
            end
            kmsa_pkg::OP_WRITE: begin
              req.ov_we    = (32'(cmd.index) < 32'(kmsa_pkg::LENGTH_MAX));
              req.ov_waddr = kmsa_pkg::ADDR_W'(cmd.index);
              req.ov_wdata = wr_acc;
              state_next   = kmsa_pkg::ST_FINISH;
            end
            default: state_next = kmsa_pkg::ST_FINISH;
          endcase
        end
      end
      kmsa_pkg::ST_EVENT: begin
        req.pa_raddr = bin[kmsa_pkg::ADDR_W-1:0];
        req.tp_raddr = cnt[kmsa_pkg::TAP_AW-1:0];
        ev_issue     = 1'b1;
        if (cnt == kmsa_pkg::CNT_W'(tap_last)) begin
          state_next = kmsa_pkg::ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      kmsa_pkg::ST_COMMIT: begin
        req.pa_raddr = cnt[kmsa_pkg::ADDR_W-1:0];
        req.ov_raddr = cnt[kmsa_pkg::ADDR_W-1:0];
        cm_issue     = 1'b1;
        if (cnt == LAST_BIN) begin
          state_next = kmsa_pkg::ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      kmsa_pkg::ST_DRAIN: state_next = kmsa_pkg::ST_FINISH;
      kmsa_pkg::ST_READ: begin
        req.ov_raddr = kmsa_pkg::ADDR_W'(idx_r);
        state_next   = kmsa_pkg::ST_RDATA;
      end
      kmsa_pkg::ST_RDATA: state_next = kmsa_pkg::ST_FINISH;
      kmsa_pkg::ST_FINISH: begin
        if (!out_valid || res.ready) begin
          finish     = 1'b1;
          state_next = kmsa_pkg::ST_IDLE;
        end
      end
      default: state_next = kmsa_pkg::ST_IDLE;
    endcase

    // Write back the bin read earlier in the walk, from the registered read data.
    if (s1_ev && (rsp.pa_rdata < rsp.tp_rdata)) begin
      req.pa_we    = 1'b1;
      req.pa_waddr = s1_addr;
      req.pa_wdata = rsp.tp_rdata;
    end
    if (s1_cm) begin
      req.pa_we    = 1'b1;
      req.pa_waddr = s1_addr;
      req.pa_wdata = '0;
      req.ov_we    = s1_ok;
      req.ov_waddr = s1_addr;
      req.ov_wdata = sum[kmsa_pkg::ACC_BITS] ? kmsa_pkg::FULL_SCALE
                                             : sum[kmsa_pkg::ACC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kmsa_pkg::ST_CLEAR;
      cnt       <= '0;
      s1_ev     <= 1'b0;
      s1_cm     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      s1_ev <= ev_issue && bin_ok;
      s1_cm <= cm_issue;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_ok   <= (cnt < kmsa_pkg::CNT_W'(len));
    s1_addr <= ev_issue ? bin[kmsa_pkg::ADDR_W-1:0] : cnt[kmsa_pkg::ADDR_W-1:0];
    if (accept) begin
      op_r     <= cmd.op;
      idx_r    <= cmd.index;
      base     <= kmsa_pkg::BIN_W'(cmd.position) - kmsa_pkg::BIN_W'(half)
                + kmsa_pkg::BIN_W'(cfg.peak_offset);
      tap_last <= kmsa_pkg::TAP_AW'({half, 1'b0});
      sat_r    <= 1'b0;
    end else if (s1_cm && s1_ok && sum[kmsa_pkg::ACC_BITS]) begin
      sat_r <= 1'b1;
    end
    if (state == kmsa_pkg::ST_RDATA) begin
      rd_r <= (32'(idx_r) < 32'(kmsa_pkg::LENGTH_MAX)) ? rsp.ov_rdata : '0;
    end
    if (finish) begin
      out_op    <= op_r;
      out_value <= (op_r == kmsa_pkg::OP_READ) ? kmsa_pkg::VAL_W'(rd_r) : '0;
      out_sat   <= (op_r == kmsa_pkg::OP_COMMIT) ? sat_r : 1'b0;
    end
  end

endmodule

// ===== design/kernel_max_splat_accumulator_core.sv =====
// Top level: kernel max-splat accumulator with command, result and APB ports.
//
// Usage:
// - cmd carries one op per beat (event, load tap, commit, read overall,
//   write overall); a beat moves when valid and ready are both high.
// - res returns exactly one beat per command: the op echo, the overall bin
//   for a read and the clip flag for a commit.
// - The APB port writes active_length, half_width and peak_offset at byte
//   addresses 0, 4 and 8; write only while no command is in flight.
// - Events and commits run a read-modify-write walk over the participant
//   store (one read port, one write port): an event over its 2*half_width+1
//   taps, a commit over all LENGTH_MAX bins; the write-back of one step
//   overlaps the read of the next.
// - One command is worked at a time; ready is high only between commands.
// - The result register holds a finished beat while res stalls; the next
//   command is taken meanwhile and waits at its end until res drains.
// - After reset a clearing pass over all LENGTH_MAX bins zeroes all three
//   stores; cmd.ready stays low during it, APB writes are taken as ever.
module kernel_max_splat_accumulator_core (
  input  logic                            clk,
  input  logic                            rst,
  kmsa_cmd_if.sink                        cmd,
  kmsa_res_if.source                      res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kmsa_pkg::PADDR_W-1:0]    paddr,
  input  logic [kmsa_pkg::PDATA_W-1:0]    pwdata,
  output logic [kmsa_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  kmsa_pkg::cfg_t     cfg;
  kmsa_pkg::mem_req_t req;
  kmsa_pkg::mem_rsp_t rsp;

  // Register file: hold the clamp-free register values.
  kmsa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: decode ops, walk bins and taps, drive the result register.
  kmsa_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .res (res),
    .req (req),
    .rsp (rsp)
  );

  // Stores: participant, overall and tap memories.
  kmsa_stores u_stores (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

endmodule
